// ===== sv/sc2a_pkg.sv =====
// shared constants, key tables and decode result type for the scancode decoder
package sc2a_pkg;

    localparam int unsigned SCAN_W  = 8;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned CODE_W  = 7;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned CODE_COUNT = 58;

    localparam logic [CODE_W-1:0] CODE_NONE   = 7'h00;
    localparam logic [CODE_W-1:0] CODE_ESCAPE = 7'h01;
    localparam logic [CODE_W-1:0] CODE_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] CODE_RSHIFT = 7'h36;
    localparam logic [CODE_W-1:0] CODE_LIMIT  = 7'(CODE_COUNT);
    localparam logic [CHAR_W-1:0] ESC_CHAR    = 7'd27;
    localparam logic [CHAR_W-1:0] NO_CHAR     = 7'h00;

    localparam logic [CHAR_W-1:0] PLAIN_MAP [0:CODE_COUNT-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
        7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [CHAR_W-1:0] SHIFT_MAP [0:CODE_COUNT-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
        7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed {
        logic              has_char;
        logic [CHAR_W-1:0] ascii_char;
        logic              shift_we;
        logic              shift_val;
    } decode_t;

endpackage

// ===== sv/scancode_set1_to_ascii_core.sv =====
// top level of the ps/2 set 1 scancode to ascii decoder
// usage:
//   s_valid/s_ready/s_scan_byte take one raw set 1 scancode byte per beat;
//   bit 7 set marks a key release, the low seven bits are the make code.
//   m_valid/m_ready/m_ascii_char deliver one decoded character per beat.
//   shift press and release only update the held shift flag; releases,
//   unmapped codes and codes past the space bar produce no output beat.
// order: a byte lands in the input register on acceptance and is decoded
//   from there; its character is then registered into the output
//   register that drives m_*.
// throughput: one byte per cycle while the output is not stalled; the
//   table lookup between the two registers is combinational.
// reset: aresetn low (synchronous) empties both registers and clears the
//   shift flag; s_ready is high after reset.
// stall: while m_ready is low a waiting character holds on m_*; a byte
//   behind it that yields a character stays in the input register, and
//   s_ready drops only once both registers are full.
module scancode_set1_to_ascii_core import sc2a_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SCAN_W-1:0] s_scan_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_ascii_char
);

    logic              in_valid_reg;
    logic [SCAN_W-1:0] in_byte_reg;
    logic              shift_held_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;

    decode_t dec;
    logic    out_free;
    logic    stage_adv;
    logic    in_take;

    sc2a_decode u_decode (
        .scan_byte  (in_byte_reg),
        .shift_held (shift_held_reg),
        .dec        (dec)
    );

    assign out_free  = !out_valid_reg || m_ready;
    // byte with no output can always retire
    assign stage_adv = in_valid_reg && (!dec.has_char || out_free);
    assign s_ready   = !in_valid_reg || stage_adv;
    assign in_take   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            shift_held_reg <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (stage_adv) begin
                in_valid_reg <= 1'b0;
            end

            if (stage_adv && dec.shift_we) begin
                shift_held_reg <= dec.shift_val;
            end

            if (stage_adv && dec.has_char) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_scan_byte;
        end
        if (stage_adv && dec.has_char) begin
            out_char_reg <= dec.ascii_char;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_ascii_char = out_char_reg;

endmodule

// ===== sv/sc2a_decode.sv =====
// combinational decode of one set 1 scancode byte against the shift flag
module sc2a_decode import sc2a_pkg::*; (
    input  logic [SCAN_W-1:0] scan_byte,
    input  logic              shift_held,
    output decode_t           dec
);

    logic [CODE_W-1:0]  code;
    logic               released;
    logic [INDEX_W-1:0] idx;
    logic [CHAR_W-1:0]  map_char;

    assign code     = scan_byte[CODE_W-1:0];
    assign released = scan_byte[SCAN_W-1];
    assign idx      = code[INDEX_W-1:0];

    always_comb begin
        if (code < CODE_LIMIT) begin
            map_char = shift_held ? SHIFT_MAP[idx] : PLAIN_MAP[idx];
        end else begin
            map_char = NO_CHAR;
        end
    end

    always_comb begin
        dec = '0;
        if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            dec.shift_we  = 1'b1;
            dec.shift_val = !released;
        end else if (released || code == CODE_NONE) begin
            dec.has_char = 1'b0;
        end else if (code == CODE_ESCAPE) begin
            dec.has_char   = 1'b1;
            dec.ascii_char = ESC_CHAR;
        end else begin
            // unmapped and out-of-table codes read as zero
            dec.has_char   = (map_char != NO_CHAR);
            dec.ascii_char = map_char;
        end
    end

endmodule

// ===== sim/scancode_set1_to_ascii_core_test.sv =====
// self-checking testbench for the ps/2 set 1 scancode to ascii decoder
module scancode_set1_to_ascii_core_test;
    import sc2a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam realtime     RUN_LIMIT    = 1_000_000ns;

    localparam logic [7:0] KEY_NONE     = 8'h00;
    localparam logic [7:0] KEY_ESC      = 8'h01;
    localparam logic [7:0] KEY_BKSP     = 8'h0E;
    localparam logic [7:0] KEY_TAB      = 8'h0F;
    localparam logic [7:0] KEY_ENTER    = 8'h1C;
    localparam logic [7:0] KEY_CTRL     = 8'h1D;
    localparam logic [7:0] KEY_LSHIFT   = 8'h2A;
    localparam logic [7:0] KEY_RSHIFT   = 8'h36;
    localparam logic [7:0] KEY_ALT      = 8'h38;
    localparam logic [7:0] KEY_SPACE    = 8'h39;
    localparam logic [7:0] KEY_CAPS     = 8'h3A;
    localparam logic [7:0] KEY_TOP      = 8'h7F;
    localparam logic [7:0] BREAK_FLAG   = 8'h80;
    localparam int unsigned KEY_TABLE_N = 58;

    localparam logic [6:0] LOWER_KEYS [0:KEY_TABLE_N-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
        7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [6:0] UPPER_KEYS [0:KEY_TABLE_N-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
        7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct {
        logic [SCAN_W-1:0] scan;
        bit                drain_first;
    } scan_item_t;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [SCAN_W-1:0] s_scan_byte  = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [CHAR_W-1:0] m_ascii_char;

    scan_item_t        scan_queue[$];
    logic [CHAR_W-1:0] char_queue[$];
    bit                shift_down = 1'b0;
    bit                s_fired    = 1'b0;
    int unsigned       err_count  = 0;
    int unsigned       tx_gap     = 0;
    int unsigned       rx_stall   = 0;
    bit                tx_quiet   = 1'b0;
    bit                rx_quiet   = 1'b0;

    scancode_set1_to_ascii_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_scan_byte  (s_scan_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // decodes one accepted byte and tracks the shift key
    function automatic void decode_key(input logic [SCAN_W-1:0] scan, output bit has_char,
                                       output logic [CHAR_W-1:0] ch);
        logic [6:0] code;
        bit         is_break;
        code     = scan[6:0];
        is_break = scan[7];
        has_char = 1'b0;
        ch       = '0;
        if (code == KEY_LSHIFT[6:0] || code == KEY_RSHIFT[6:0]) begin
            shift_down = !is_break;
        end else if (!is_break && code != KEY_NONE[6:0]) begin
            if (code == KEY_ESC[6:0]) begin
                ch = 7'd27;
            end else if (code < KEY_TABLE_N) begin
                ch = shift_down ? UPPER_KEYS[code] : LOWER_KEYS[code];
            end
            has_char = (ch != '0);
        end
    endfunction

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_scan(input logic [SCAN_W-1:0] scan, input bit drain_first);
        scan_item_t item;
        item.scan        = scan;
        item.drain_first = drain_first;
        scan_queue.push_back(item);
    endfunction

    // sender: next beat goes out at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(63) == 0)
                tx_quiet = !tx_quiet;
            if (!s_valid || s_fired) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (scan_queue.size() > 0 &&
                             !(scan_queue[0].drain_first && char_queue.size() > 0)) begin
                    s_valid     <= 1'b1;
                    s_scan_byte <= scan_queue[0].scan;
                    void'(scan_queue.pop_front());
                    tx_gap = pick_gap(tx_quiet);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(63) == 0)
                rx_quiet = !rx_quiet;
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(7) == 0)
                    rx_stall = pick_gap(rx_quiet);
            end
        end
    end

    always @(posedge aclk) begin
        bit                has_char;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] want;
        s_fired = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                s_fired = 1'b1;
                decode_key(s_scan_byte, has_char, ch);
                if (has_char)
                    char_queue.push_back(ch);
            end
            if (m_valid && m_ready) begin
                if (char_queue.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected beat: ascii_char=%h", m_ascii_char);
                end else begin
                    want = char_queue.pop_front();
                    if (m_ascii_char !== want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("ascii_char mismatch: expected %h, got %h",
                                     want, m_ascii_char);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned kind;
        int unsigned keys;
        logic [7:0]  key;
        logic [7:0]  shift_key;

        // corner cases first
        queue_scan(KEY_NONE, 1'b0);
        queue_scan(KEY_NONE | BREAK_FLAG, 1'b0);
        queue_scan(KEY_ESC, 1'b0);
        queue_scan(8'h02, 1'b0);
        queue_scan(KEY_LSHIFT, 1'b0);
        queue_scan(8'h02, 1'b0);
        queue_scan(8'h10, 1'b0);
        queue_scan(KEY_ESC, 1'b0);
        queue_scan(KEY_ENTER, 1'b0);
        queue_scan(KEY_CTRL, 1'b0);
        queue_scan(KEY_BKSP, 1'b0);
        queue_scan(KEY_TAB, 1'b1);
        queue_scan(KEY_SPACE, 1'b0);
        queue_scan(8'h37, 1'b0);
        queue_scan(KEY_CAPS, 1'b0);
        queue_scan(KEY_ALT, 1'b0);
        queue_scan(KEY_LSHIFT | BREAK_FLAG, 1'b0);
        queue_scan(8'h10, 1'b0);
        queue_scan(KEY_RSHIFT, 1'b0);
        queue_scan(8'h35, 1'b0);
        queue_scan(8'h92, 1'b0);
        queue_scan(KEY_TOP, 1'b0);
        queue_scan(KEY_RSHIFT | BREAK_FLAG, 1'b0);
        queue_scan(8'h29, 1'b0);
        queue_scan(8'hFF, 1'b0);
        queue_scan(8'h2B, 1'b0);

        // mostly realistic typing, shifted words and some line noise
        while (scan_queue.size() < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                queue_scan(8'($urandom_range(255)), 1'b0);
            end else if (kind < 50) begin
                shift_key = $urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT;
                queue_scan(shift_key, 1'b0);
                keys = $urandom_range(1, 6);
                repeat (keys) begin
                    key = 8'($urandom_range(1, KEY_SPACE));
                    queue_scan(key, 1'b0);
                    if ($urandom_range(3) != 0)
                        queue_scan(key | BREAK_FLAG, 1'b0);
                end
                if ($urandom_range(9) != 0)
                    queue_scan(shift_key | BREAK_FLAG, 1'b0);
            end else begin
                if ($urandom_range(9) == 0)
                    key = 8'($urandom_range(0, KEY_TOP));
                else
                    key = 8'($urandom_range(1, KEY_SPACE));
                queue_scan(key, 1'b0);
                if ($urandom_range(9) < 7)
                    queue_scan(key | BREAK_FLAG, 1'b0);
            end
        end
        scan_queue[scan_queue.size() / 2].drain_first = 1'b1;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        while (scan_queue.size() > 0 || s_valid)
            @(posedge aclk);
        while (char_queue.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0 && char_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sc2a_pkg.sv
sv/sc2a_decode.sv
sv/scancode_set1_to_ascii_core.sv
sim/scancode_set1_to_ascii_core_test.sv
